@@ design/touch_release_tracker_top_defines.svh @@
// Assertion macros for the touch release tracker.
// Used by the queue, front and back modules; needs nothing else.
`ifndef TOUCH_RELEASE_TRACKER_TOP_DEFINES_SVH
`define TOUCH_RELEASE_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define TRT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("touch release tracker: assertion failed");

`define TRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch release tracker: assertion failed");

`else

`define TRT_ASSERT(label, clk, rst, prop)

`define TRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/trt_pkg.sv @@
// Shared constants, types and state codes of the touch release tracker.
// Depends on nothing; every other file but the assertion macro header uses it.
`default_nettype none

package trt_pkg;

   localparam int MAX_POINTS  = 10;
   localparam int ID_W        = 8;
   localparam int COORD_W     = 16;
   localparam int TOTAL_W     = 4;
   localparam int IDX_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int FILL_W      = $clog2(MAX_POINTS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ID_W-1:0]       id_type;
   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [TOTAL_W-1:0]    total_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [FILL_W-1:0]     fill_type;
   typedef logic [MAX_POINTS-1:0] mask_type;
   typedef logic [QPTR_W-1:0]     qptr_type;
   typedef logic [QCNT_W-1:0]     qcnt_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } point_type;

   typedef struct packed {
      logic      store;
      logic      close;
      logic      contact;
      id_type    id;
      point_type pt;
      mask_type  mask;
   } cmd_type;

   typedef struct packed {
      logic      contact;
      id_type    id;
      point_type pt;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_WALK = 3'b010,
      BK_FIN  = 3'b100
   } back_state_type;

endpackage

`default_nettype wire

@@ design/trt_if.sv @@
// Valid/ready channel interfaces for touch points in and report beats out.
// Depends on trt_pkg.
`default_nettype none

interface trt_req_if;
   logic                  valid;
   logic                  ready;
   logic                  contact;
   trt_pkg::id_type       point_id;
   trt_pkg::coord_type    pos_x;
   trt_pkg::coord_type    pos_y;
   trt_pkg::coord_type    touch_width;
   trt_pkg::coord_type    touch_height;
   logic                  frame_end;

   modport source (output valid, contact, point_id, pos_x, pos_y, touch_width,
                   touch_height, frame_end, input ready);
   modport sink (input valid, contact, point_id, pos_x, pos_y, touch_width,
                 touch_height, frame_end, output ready);
endinterface

interface trt_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  out_contact;
   trt_pkg::id_type       out_id;
   trt_pkg::coord_type    out_x;
   trt_pkg::coord_type    out_y;
   trt_pkg::coord_type    out_width;
   trt_pkg::coord_type    out_height;
   logic                  report_last;
   trt_pkg::total_type    point_total;

   modport source (output valid, out_contact, out_id, out_x, out_y, out_width,
                   out_height, report_last, point_total, input ready);
   modport sink (input valid, out_contact, out_id, out_x, out_y, out_width,
                 out_height, report_last, point_total, output ready);
endinterface

`default_nettype wire

@@ design/touch_release_tracker_top.sv @@
// Touch release tracker top level: front, command queue and back part.
// Depends on trt_pkg, trt_if, trt_front, trt_queue and trt_back.
//
// Usage: req_bus carries one touch point per beat, frame_end set on the last
// point of a frame. rsp_bus returns an echo of every stored point and, after
// a frame's last point, one beat with contact cleared for each tracked id
// that was present last frame and is now gone and fits a free slot, in
// ascending id order. The final beat of a frame report carries report_last
// and point_total. Points beyond MAX_POINTS slots in a frame are dropped
// without an echo. A point that does not close its frame passes the queue
// and the back part's output register before its echo. The closing point
// starts a walk over all MAX_POINTS ids in the back part, one id per cycle
// while the output does not stall, then a finish step flushes the held beat.
// Throughput: one point per cycle within a frame while the queue is not full;
// a closing point occupies the back part for its whole walk while a two-entry
// queue keeps the front taking points.
// Reset clears the slot fill counts and presence mask; the first frame
// reports no releases. When rsp_bus stalls the output beat is held, the back
// part waits, the queue fills and req_bus.ready drops.
`default_nettype none

module touch_release_tracker_top (
   input  logic      clock,
   input  logic      reset,
   trt_req_if.sink   req_bus,
   trt_rsp_if.source rsp_bus
);

   logic             q_full;
   logic             push;
   trt_pkg::cmd_type push_cmd;
   logic             pop;
   logic             head_valid;
   trt_pkg::cmd_type head_cmd;

   trt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   trt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   trt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

@@ design/trt_queue.sv @@
// Two-entry command queue between the front and back parts.
// Depends on trt_pkg and the assertion macro header.
`default_nettype none
`include "touch_release_tracker_top_defines.svh"

module trt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  trt_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output trt_pkg::cmd_type head_cmd
);

   trt_pkg::cmd_type  slot_ff [trt_pkg::QUEUE_DEPTH];
   trt_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   trt_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   trt_pkg::qcnt_type count_ff, count_in;

   assign full       = (count_ff == trt_pkg::qcnt_type'(trt_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + trt_pkg::qptr_type'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + trt_pkg::qptr_type'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + trt_pkg::qcnt_type'(1);
         2'b01:   count_in = count_ff - trt_pkg::qcnt_type'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TRT_ASSERT(a_queue_no_overflow, clock, reset, push |-> !full)
   `TRT_ASSERT(a_queue_no_underflow, clock, reset, pop |-> head_valid)

endmodule

`default_nettype wire

@@ design/trt_front.sv @@
// Front part: accepts touch point beats, drops overflow, tracks present ids.
// Depends on trt_pkg, trt_if and the assertion macro header.
`default_nettype none
`include "touch_release_tracker_top_defines.svh"

module trt_front (
   input  logic             clock,
   input  logic             reset,
   trt_req_if.sink          req,
   input  logic             q_full,
   output logic             push,
   output trt_pkg::cmd_type push_cmd
);

   trt_pkg::fill_type fill_ff, fill_in;
   trt_pkg::mask_type mask_ff, mask_in;
   trt_pkg::mask_type id_bit;
   logic              accept;
   logic              store;
   logic              tracked;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign store     = (fill_ff < trt_pkg::fill_type'(trt_pkg::MAX_POINTS));
   assign tracked   = (req.point_id < trt_pkg::id_type'(trt_pkg::MAX_POINTS));
   assign id_bit    = (store && tracked) ?
                      (trt_pkg::mask_type'(1) << req.point_id[trt_pkg::IDX_W-1:0]) : '0;

   assign push             = accept && (store || req.frame_end);
   assign push_cmd.store   = store;
   assign push_cmd.close   = req.frame_end;
   assign push_cmd.contact = req.contact;
   assign push_cmd.id      = req.point_id;
   assign push_cmd.pt.x    = req.pos_x;
   assign push_cmd.pt.y    = req.pos_y;
   assign push_cmd.pt.w    = req.touch_width;
   assign push_cmd.pt.h    = req.touch_height;
   assign push_cmd.mask    = mask_ff | id_bit;

   always_comb begin
      fill_in = fill_ff;
      mask_in = mask_ff;
      if (accept) begin
         if (req.frame_end) begin
            fill_in = '0;
            mask_in = '0;
         end else if (store) begin
            fill_in = fill_ff + trt_pkg::fill_type'(1);
            mask_in = mask_ff | id_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         mask_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         mask_ff <= mask_in;
      end
   end

   `TRT_ASSERT(a_front_fill_bound, clock, reset,
               fill_ff <= trt_pkg::fill_type'(trt_pkg::MAX_POINTS))

endmodule

`default_nettype wire

@@ design/trt_back.sv @@
// Back part: stores frame slots, walks released ids and drives report beats.
// Depends on trt_pkg, trt_if and the assertion macro header.
`default_nettype none
`include "touch_release_tracker_top_defines.svh"

module trt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  trt_pkg::cmd_type head_cmd,
   output logic             pop,
   trt_rsp_if.source        rsp
);

   trt_pkg::back_state_type state_ff, state_in;
   trt_pkg::idx_type        walk_idx_ff, walk_idx_in;
   trt_pkg::mask_type       released_ff, released_in;
   trt_pkg::mask_type       new_mask_ff, new_mask_in;
   trt_pkg::mask_type       active_ff, active_in;
   trt_pkg::fill_type       fill_ff, fill_in;
   trt_pkg::fill_type       prev_fill_ff, prev_fill_in;
   logic                    hold_valid_ff, hold_valid_in;
   trt_pkg::result_type     hold_ff, hold_in;
   logic                    out_valid_ff, out_valid_in;
   trt_pkg::result_type     out_ff, out_in;
   logic                    out_last_ff, out_last_in;
   trt_pkg::total_type      out_total_ff, out_total_in;

   trt_pkg::id_type         cur_id_ff  [trt_pkg::MAX_POINTS];
   trt_pkg::point_type      cur_pt_ff  [trt_pkg::MAX_POINTS];
   trt_pkg::id_type         prev_id_ff [trt_pkg::MAX_POINTS];
   trt_pkg::point_type      prev_pt_ff [trt_pkg::MAX_POINTS];

   logic                    can_push;
   logic                    match_hit;
   trt_pkg::idx_type        match_idx;
   logic                    rel_go;
   trt_pkg::result_type     echo_res;
   trt_pkg::result_type     rel_res;
   logic                    wr_en;
   trt_pkg::result_type     wr_res;
   logic                    copy_en;
   logic                    out_load;

   assign can_push = !out_valid_ff || rsp.ready;

   // first slot of the previous frame holding the id under walk
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      for (int j = trt_pkg::MAX_POINTS - 1; j >= 0; j--) begin
         if ((trt_pkg::fill_type'(j) < prev_fill_ff) &&
             (prev_id_ff[j] == trt_pkg::id_type'(walk_idx_ff))) begin
            match_hit = 1'b1;
            match_idx = trt_pkg::idx_type'(j);
         end
      end
   end

   assign rel_go = released_ff[walk_idx_ff] && match_hit &&
                   (fill_ff < trt_pkg::fill_type'(trt_pkg::MAX_POINTS));

   assign echo_res.contact = head_cmd.contact;
   assign echo_res.id      = head_cmd.id;
   assign echo_res.pt      = head_cmd.pt;
   assign rel_res.contact  = 1'b0;
   assign rel_res.id       = trt_pkg::id_type'(walk_idx_ff);
   assign rel_res.pt       = prev_pt_ff[match_idx];

   always_comb begin
      state_in      = state_ff;
      walk_idx_in   = walk_idx_ff;
      released_in   = released_ff;
      new_mask_in   = new_mask_ff;
      active_in     = active_ff;
      fill_in       = fill_ff;
      prev_fill_in  = prev_fill_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_total_in  = out_total_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_res        = echo_res;
      copy_en       = 1'b0;
      out_load      = 1'b0;

      unique case (state_ff)
         trt_pkg::BK_IDLE: begin
            if (head_valid && !(head_cmd.store && !head_cmd.close && !can_push)) begin
               pop = 1'b1;
               if (head_cmd.store) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + trt_pkg::fill_type'(1);
                  if (head_cmd.close) begin
                     hold_valid_in = 1'b1;
                     hold_in       = echo_res;
                  end else begin
                     out_load     = 1'b1;
                     out_in       = echo_res;
                     out_last_in  = 1'b0;
                     out_total_in = '0;
                  end
               end
               if (head_cmd.close) begin
                  state_in    = trt_pkg::BK_WALK;
                  walk_idx_in = '0;
                  released_in = active_ff & ~head_cmd.mask;
                  new_mask_in = head_cmd.mask;
               end
            end
         end
         trt_pkg::BK_WALK: begin
            if (!(rel_go && hold_valid_ff && !can_push)) begin
               if (rel_go) begin
                  wr_en         = 1'b1;
                  wr_res        = rel_res;
                  fill_in       = fill_ff + trt_pkg::fill_type'(1);
                  hold_valid_in = 1'b1;
                  hold_in       = rel_res;
                  if (hold_valid_ff) begin
                     out_load     = 1'b1;
                     out_in       = hold_ff;
                     out_last_in  = 1'b0;
                     out_total_in = '0;
                  end
               end
               if (walk_idx_ff == trt_pkg::idx_type'(trt_pkg::MAX_POINTS - 1)) begin
                  state_in = trt_pkg::BK_FIN;
               end else begin
                  walk_idx_in = walk_idx_ff + trt_pkg::idx_type'(1);
               end
            end
         end
         trt_pkg::BK_FIN: begin
            if (!(hold_valid_ff && !can_push)) begin
               copy_en      = 1'b1;
               fill_in      = '0;
               prev_fill_in = fill_ff;
               active_in    = new_mask_ff;
               state_in     = trt_pkg::BK_IDLE;
               if (hold_valid_ff) begin
                  out_load      = 1'b1;
                  out_in        = hold_ff;
                  out_last_in   = 1'b1;
                  out_total_in  = trt_pkg::total_type'(fill_ff);
                  hold_valid_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = trt_pkg::BK_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trt_pkg::BK_IDLE;
         walk_idx_ff   <= '0;
         released_ff   <= '0;
         new_mask_ff   <= '0;
         active_ff     <= '0;
         fill_ff       <= '0;
         prev_fill_ff  <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_idx_ff   <= walk_idx_in;
         released_ff   <= released_in;
         new_mask_ff   <= new_mask_in;
         active_ff     <= active_in;
         fill_ff       <= fill_in;
         prev_fill_ff  <= prev_fill_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      out_ff       <= out_in;
      out_last_ff  <= out_last_in;
      out_total_ff <= out_total_in;
      if (wr_en) begin
         cur_id_ff[fill_ff[trt_pkg::IDX_W-1:0]] <= wr_res.id;
         cur_pt_ff[fill_ff[trt_pkg::IDX_W-1:0]] <= wr_res.pt;
      end
      if (copy_en) begin
         prev_id_ff <= cur_id_ff;
         prev_pt_ff <= cur_pt_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_contact = out_ff.contact;
   assign rsp.out_id      = out_ff.id;
   assign rsp.out_x       = out_ff.pt.x;
   assign rsp.out_y       = out_ff.pt.y;
   assign rsp.out_width   = out_ff.pt.w;
   assign rsp.out_height  = out_ff.pt.h;
   assign rsp.report_last = out_last_ff;
   assign rsp.point_total = out_total_ff;

   `TRT_ASSERT(a_back_fill_bound, clock, reset,
               fill_ff <= trt_pkg::fill_type'(trt_pkg::MAX_POINTS))
   `TRT_ASSERT_NEXT(a_back_close_flush, clock, reset,
                    (state_ff == trt_pkg::BK_FIN) && hold_valid_ff && can_push,
                    rsp.valid && rsp.report_last)

endmodule

`default_nettype wire

@@ bench/touch_release_tracker_top_checker.sv @@
// Checker for the touch release tracker: watches both channels, tracks contact
// lifts frame by frame and compares every report beat. Depends on trt_pkg, trt_if.
module touch_release_tracker_checker
   import trt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   trt_req_if          req_bus,
   trt_rsp_if          rsp_bus,
   output int unsigned fault_count,
   output int unsigned pending_count
);

   typedef struct packed {
      logic      contact;
      id_type    id;
      point_type pt;
      logic      last;
      total_type total;
   } report_beat_type;

   id_type          held_ids [MAX_POINTS];
   point_type       held_pts [MAX_POINTS];
   mask_type        live_mask;
   id_type          frame_ids [MAX_POINTS];
   point_type       frame_pts [MAX_POINTS];
   int              frame_fill;
   report_beat_type due_beats [$];

   assign pending_count = due_beats.size();

   function automatic void clear_frame();
      for (int i = 0; i < MAX_POINTS; i++) begin
         frame_ids[i] = 8'hFF;
         frame_pts[i] = '0;
      end
      frame_fill = 0;
   endfunction

   function automatic report_beat_type make_beat(logic contact, id_type id, point_type pt);
      report_beat_type b;
      b.contact = contact;
      b.id      = id;
      b.pt      = pt;
      b.last    = 1'b0;
      b.total   = '0;
      return b;
   endfunction

   function automatic void track_point(logic contact, id_type id, point_type pt,
                                       logic close);
      report_beat_type batch [MAX_POINTS + 1];
      int              produced;
      mask_type        seen;
      mask_type        lifted;
      logic            found;
      produced = 0;
      if (frame_fill < MAX_POINTS) begin
         frame_ids[frame_fill] = id;
         frame_pts[frame_fill] = pt;
         frame_fill++;
         batch[produced] = make_beat(contact, id, pt);
         produced++;
      end
      if (close) begin
         seen = '0;
         for (int i = 0; i < frame_fill; i++)
            if (frame_ids[i] < MAX_POINTS)
               seen[frame_ids[i]] = 1'b1;
         lifted = live_mask & ~seen;
         for (int i = 0; i < MAX_POINTS; i++) begin
            if (lifted[i] && frame_fill < MAX_POINTS) begin
               found = 1'b0;
               for (int j = 0; j < MAX_POINTS; j++) begin
                  if (!found && held_ids[j] == id_type'(i)) begin
                     found = 1'b1;
                     frame_ids[frame_fill] = held_ids[j];
                     frame_pts[frame_fill] = held_pts[j];
                     frame_fill++;
                     batch[produced] = make_beat(1'b0, id_type'(i), held_pts[j]);
                     produced++;
                  end
               end
            end
         end
         if (produced > 0) begin
            batch[produced-1].last  = 1'b1;
            batch[produced-1].total = total_type'(frame_fill);
         end
         for (int i = 0; i < MAX_POINTS; i++) begin
            held_ids[i] = frame_ids[i];
            held_pts[i] = frame_pts[i];
         end
         live_mask = seen;
         clear_frame();
      end
      for (int k = 0; k < produced; k++)
         due_beats.push_back(batch[k]);
   endfunction

   function automatic void report_fault(string what, report_beat_type exp_b,
                                        report_beat_type act_b);
      fault_count++;
      if (fault_count <= 10)
         $display("%s: expected c%0b id %0d x %h y %h w %h h %h last %0b total %0d, got c%0b id %0d x %h y %h w %h h %h last %0b total %0d",
                  what, exp_b.contact, exp_b.id, exp_b.pt.x, exp_b.pt.y, exp_b.pt.w,
                  exp_b.pt.h, exp_b.last, exp_b.total, act_b.contact, act_b.id,
                  act_b.pt.x, act_b.pt.y, act_b.pt.w, act_b.pt.h, act_b.last,
                  act_b.total);
   endfunction

   always @(posedge clock) begin
      report_beat_type got;
      report_beat_type want;
      point_type       in_pt;
      if (reset) begin
         for (int i = 0; i < MAX_POINTS; i++) begin
            held_ids[i] = '0;
            held_pts[i] = '0;
         end
         live_mask = '0;
         clear_frame();
         due_beats.delete();
         fault_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            in_pt.x = req_bus.pos_x;
            in_pt.y = req_bus.pos_y;
            in_pt.w = req_bus.touch_width;
            in_pt.h = req_bus.touch_height;
            track_point(req_bus.contact, req_bus.point_id, in_pt, req_bus.frame_end);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.contact = rsp_bus.out_contact;
            got.id      = rsp_bus.out_id;
            got.pt.x    = rsp_bus.out_x;
            got.pt.y    = rsp_bus.out_y;
            got.pt.w    = rsp_bus.out_width;
            got.pt.h    = rsp_bus.out_height;
            got.last    = rsp_bus.report_last;
            got.total   = rsp_bus.point_total;
            if (due_beats.size() == 0) begin
               report_fault("unexpected beat", '0, got);
            end else begin
               want = due_beats.pop_front();
               if (got !== want)
                  report_fault("beat differs", want, got);
            end
         end
      end
   end

endmodule

@@ bench/touch_release_tracker_top_tb.sv @@
// Testbench top for the touch release tracker: clock, reset, touch frames in,
// randomly stalled report sink and the verdict. Depends on trt_pkg, trt_if,
// the checker and touch_release_tracker_top.
module touch_release_tracker_top_tb;
   import trt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        steady = 1'b0;
   int unsigned fault_count;
   int unsigned pending_count;
   int          items_sent = 0;

   trt_req_if req_bus ();
   trt_rsp_if rsp_bus ();

   touch_release_tracker_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   touch_release_tracker_checker lift_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= 6);
      end
   end

   initial begin
      #3200000;
      $display("touch_release_tracker_top: mismatch");
      $finish;
   end

   function automatic point_type make_point(coord_type x, coord_type y, coord_type w,
                                            coord_type h);
      point_type p;
      p.x = x;
      p.y = y;
      p.w = w;
      p.h = h;
      return p;
   endfunction

   function automatic point_type random_point();
      return make_point(coord_type'($urandom), coord_type'($urandom),
                        coord_type'($urandom), coord_type'($urandom));
   endfunction

   task automatic send_point(logic contact, id_type id, point_type pt, logic close);
      if (!steady && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.contact      <= contact;
      req_bus.point_id     <= id;
      req_bus.pos_x        <= pt.x;
      req_bus.pos_y        <= pt.y;
      req_bus.touch_width  <= pt.w;
      req_bus.touch_height <= pt.h;
      req_bus.frame_end    <= close;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   initial begin
      mask_type held;
      id_type   frame_list [16];
      id_type   tmp;
      int       n;
      int       k;
      int       frame_no;
      req_bus.valid        = 1'b0;
      req_bus.contact      = 1'b0;
      req_bus.point_id     = '0;
      req_bus.pos_x        = '0;
      req_bus.pos_y        = '0;
      req_bus.touch_width  = '0;
      req_bus.touch_height = '0;
      req_bus.frame_end    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes and an untracked id
      send_point(1'b1, 8'd0, make_point(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF), 1'b0);
      send_point(1'b0, 8'd9, make_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
      send_point(1'b1, 8'd255, make_point(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1);
      // lift id 0
      send_point(1'b1, 8'd9, random_point(), 1'b1);
      // duplicate ids, lift id 9
      send_point(1'b1, 8'd3, random_point(), 1'b0);
      send_point(1'b1, 8'd3, random_point(), 1'b0);
      send_point(1'b1, 8'd5, random_point(), 1'b1);
      // lift both, first copy of id 3
      send_point(1'b0, 8'd7, random_point(), 1'b1);
      // fill the frame, close on a dropped point with nothing to report
      for (int i = 0; i < MAX_POINTS; i++)
         send_point(1'b1, id_type'(i), random_point(), 1'b0);
      send_point(1'b1, 8'd42, random_point(), 1'b1);
      // more lifts than free slots
      send_point(1'b1, 8'd200, random_point(), 1'b1);

      held = '0;
      frame_no = 0;
      while (items_sent < 160) begin
         steady = (frame_no >= 12 && frame_no < 30);
         for (int i = 0; i < MAX_POINTS; i++)
            if ($urandom_range(99) < 20)
               held[i] = ~held[i];
         n = 0;
         for (int i = 0; i < MAX_POINTS; i++)
            if (held[i]) begin
               frame_list[n] = id_type'(i);
               n++;
            end
         if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) begin
               frame_list[n] = id_type'($urandom_range(0, 255));
               n++;
            end
         if ($urandom_range(99) < 5)
            while (n < 12) begin
               frame_list[n] = id_type'($urandom_range(0, MAX_POINTS - 1));
               n++;
            end
         if (n == 0) begin
            frame_list[0] = id_type'($urandom_range(0, 255));
            n = 1;
         end
         for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = frame_list[i];
            frame_list[i] = frame_list[k];
            frame_list[k] = tmp;
         end
         for (int i = 0; i < n; i++)
            send_point($urandom_range(99) < 85, frame_list[i], random_point(), i == n - 1);
         frame_no++;
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (4 * MAX_POINTS) @(posedge clock);
      if (fault_count == 0 && pending_count == 0) begin
         $display("touch_release_tracker_top: match");
      end else begin
         $display("touch_release_tracker_top: mismatch");
      end
      $finish;
   end

endmodule
